// ===== rtl/plwu_pkg.sv =====
package plwu_pkg;

  localparam int unsigned MaxLandmarksDef = 64;
  localparam int unsigned AngleBitsDef    = 16;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned IdW     = 10;
  localparam int unsigned HeadW   = 16;
  localparam int unsigned WeightW = 40;
  localparam int unsigned IvW     = 24;
  localparam int unsigned CntW    = 7;
  localparam int unsigned SlotW   = 6;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;

  typedef enum logic [1:0] {
    OpLoad = 2'd0,
    OpPose = 2'd1,
    OpObs  = 2'd2,
    OpNone = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CfgCount = 2'd0,
    CfgIvx   = 2'd1,
    CfgIvy   = 2'd2,
    CfgNorm  = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    StIdle,
    StPoly,
    StPolyMul,
    StRotMul,
    StRotSum,
    StScan,
    StExpMul,
    StExpSum,
    StOut
  } bst_e;

  // polynomial coefficients, Q30, innermost first
  localparam logic [30:0] SinCoef [5] = '{
    31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
  };

  // one queued command between front and back
  typedef struct packed {
    op_e                op;
    logic [SlotW-1:0]   slot;
    logic               slot_ok;
    logic [IdW-1:0]     id;
    logic [CoordW-1:0]  xv;
    logic [CoordW-1:0]  yv;
    logic [HeadW-1:0]   head;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic [SlotW-1:0]   idx;
    logic [IdW-1:0]     id;
    logic [CoordW-1:0]  x;
    logic [CoordW-1:0]  y;
    logic [WeightW-1:0] w;
    logic               fin;
  } res_t;

endpackage

// ===== rtl/particle_landmark_weight_update.sv =====
// Channel  | Direction | Handshake      | Payload
// input    | in        | push_i/full_o  | op, entry_index, landmark_id, x, y, heading, last
// result   | out       | empty_o/pop_i  | nearest_*, log_weight, weight_final
// config   | in        | cfg_we_i       | cfg_index_i, cfg_data_i
// Load and pose items complete in the back end straight from idle; an observation
// starts, evaluates the sine polynomial, rotates the offset, then scans the table,
// one table entry read per cycle from the landmark memory, then computes the weight.
// A two-item queue separates acceptance from execution.
// Reset clears pose, weight and queues; the landmark table needs loading.
// An observation waits while an undelivered result occupies the output register.
module particle_landmark_weight_update #(
  parameter int unsigned MaxLandmarks = plwu_pkg::MaxLandmarksDef,
  parameter int unsigned AngleBits    = plwu_pkg::AngleBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [1:0]  op_i,
  input  logic [5:0]  entry_index_i,
  input  logic [9:0]  landmark_id_i,
  input  logic [31:0] x_value_i,
  input  logic [31:0] y_value_i,
  input  logic [15:0] heading_i,
  input  logic        last_observation_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [5:0]  nearest_index_o,
  output logic [9:0]  nearest_id_o,
  output logic [31:0] nearest_x_o,
  output logic [31:0] nearest_y_o,
  output logic [39:0] log_weight_o,
  output logic        weight_final_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import plwu_pkg::*;

  logic        cmd_valid, cmd_take, res_valid;
  cmd_t        cmd;
  res_t        res;
  logic [6:0]  cnt_q;
  logic [23:0] ivx_q, ivy_q;
  logic [31:0] norm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 7'd64;
      ivx_q  <= 24'd65536;
      ivy_q  <= 24'd65536;
      norm_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_index_i))
        CfgCount: cnt_q  <= cfg_data_i[6:0];
        CfgIvx:   ivx_q  <= cfg_data_i[23:0];
        CfgIvy:   ivy_q  <= cfg_data_i[23:0];
        CfgNorm:  norm_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  plwu_front #(.MaxLandmarks(MaxLandmarks)) u_front (
    .clk_i, .rst_ni, .push_i, .full_o, .op_i, .entry_index_i, .landmark_id_i,
    .x_value_i, .y_value_i, .heading_i, .last_observation_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take)
  );

  plwu_back #(.MaxLandmarks(MaxLandmarks), .AngleBits(AngleBits)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .cnt_cfg_i(cnt_q), .ivx_i(ivx_q), .ivy_i(ivy_q), .norm_i(norm_q),
    .res_valid_o(res_valid), .res_o(res), .res_take_i(pop_i && res_valid)
  );

  assign empty_o         = !res_valid;
  assign nearest_index_o = res.idx;
  assign nearest_id_o    = res.id;
  assign nearest_x_o     = res.x;
  assign nearest_y_o     = res.y;
  assign log_weight_o    = res.w;
  assign weight_final_o  = res.fin;

`ifndef SYNTH
  a_take_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take |-> cmd_valid) else $error("command taken from empty queue");
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(log_weight_o)))
    else $error("result lost before pop");
`endif
endmodule

// ===== rtl/plwu_front.sv =====
module plwu_front #(
  parameter int unsigned MaxLandmarks = plwu_pkg::MaxLandmarksDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [1:0]            op_i,
  input  logic [5:0]            entry_index_i,
  input  logic [9:0]            landmark_id_i,
  input  logic [31:0]           x_value_i,
  input  logic [31:0]           y_value_i,
  input  logic [15:0]           heading_i,
  input  logic                  last_observation_i,
  output logic                  cmd_valid_o,
  output plwu_pkg::cmd_t        cmd_o,
  input  logic                  cmd_take_i
);
  import plwu_pkg::*;

  // two-entry queue; unused ops and loads to out-of-range slots are dropped here
  cmd_t        mem_q [2];
  logic        wp_q, wp_d, rp_q, rp_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        acc, keep;
  cmd_t        c;

  assign full_o = (cnt_q == 2'd2);
  assign acc    = push_i && !full_o;

  always_comb begin
    c.op      = op_e'(op_i);
    c.slot    = entry_index_i;
    c.slot_ok = ({26'd0, entry_index_i} < 32'(MaxLandmarks));
    c.id      = landmark_id_i;
    c.xv      = x_value_i;
    c.yv      = y_value_i;
    c.head    = heading_i;
    c.last    = last_observation_i;
    keep      = acc && (c.op != OpNone) && !(c.op == OpLoad && !c.slot_ok);
  end

  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q ^ keep;
    rp_d  = rp_q ^ cmd_take_i;
    cnt_d = cnt_q + {1'b0, keep} - {1'b0, cmd_take_i};
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      mem_q[wp_q] <= c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

// ===== rtl/plwu_back.sv =====
module plwu_back #(
  parameter int unsigned MaxLandmarks = plwu_pkg::MaxLandmarksDef,
  parameter int unsigned AngleBits    = plwu_pkg::AngleBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  input  plwu_pkg::cmd_t         cmd_i,
  output logic                   cmd_take_o,
  input  logic [6:0]             cnt_cfg_i,
  input  logic [23:0]            ivx_i,
  input  logic [23:0]            ivy_i,
  input  logic [31:0]            norm_i,
  output logic                   res_valid_o,
  output plwu_pkg::res_t         res_o,
  input  logic                   res_take_i
);
  import plwu_pkg::*;

  localparam int unsigned AW = (MaxLandmarks > 1) ? $clog2(MaxLandmarks) : 1;
  localparam int unsigned NW = $clog2(MaxLandmarks + 1);

  // landmark table
  logic [CoordW-1:0] tx_mem [MaxLandmarks];
  logic [CoordW-1:0] ty_mem [MaxLandmarks];
  logic [IdW-1:0]    tid_mem [MaxLandmarks];
  logic [CoordW-1:0] rx_q, ry_q;
  logic [IdW-1:0]    rid_q;
  logic [AW-1:0]     raddr;

  bst_e st_q, st_d;

  logic [CoordW-1:0]  px_q, py_q;
  logic [HeadW-1:0]   ph_q;
  logic [WeightW-1:0] ws_q;
  cmd_t               cur_q;

  // polynomial sequencer: each coefficient takes a multiply step and an accumulate step
  logic [30:0] xa_q, xc_q;       // sine arg, cosine arg (Q30)
  logic [30:0] x2a_q, x2c_q;
  logic [31:0] sa_q, sc_q;
  logic [2:0]  k_q;
  logic [1:0]  quad_q;
  logic [62:0] pa_q, pc_q;

  logic signed [63:0] m1_q, m2_q, m3_q, m4_q;
  logic signed [CoordW-1:0] mx_q, my_q;

  logic [NW-1:0]  j_q;
  logic [NW-1:0]  n_lim;
  logic           rd_ok_q;
  logic [AW-1:0]  rd_j_q;
  logic [AW-1:0]  best_q;
  logic [64:0]    bestd_q;
  logic           have_q;
  logic [32:0]    dx, dy;
  logic [65:0]    dsum;
  logic [32:0]    bdx_q, bdy_q;
  logic [IdW-1:0] bid_q;
  logic [CoordW-1:0] bx_q, by_q;
  logic [65:0]    sqx_q, sqy_q;
  logic [60:0]    ex_q, ey_q;
  logic [60:0]    e_sum;
  logic signed [41:0] w_next;
  res_t           res_q;
  logic           rv_q;

  function automatic logic [32:0] absd(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sh07fffffff) return 32'h7fffffff;
    if (v < -34'sh080000000) return 32'h80000000;
    return v[31:0];
  endfunction

  assign n_lim = (cnt_cfg_i == 7'd0) ? NW'(1) :
                 ({25'd0, cnt_cfg_i} > 32'(MaxLandmarks)) ? NW'(MaxLandmarks) :
                 NW'(cnt_cfg_i);

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:    if (cmd_valid_i && cmd_i.op == OpObs && !rv_q) st_d = StPoly;
      StPoly:    st_d = StPolyMul;
      StPolyMul: st_d = (k_q == 3'd5) ? StRotMul : StPoly;
      StRotMul:  st_d = StRotSum;
      StRotSum:  st_d = StScan;
      StScan:    if (!rd_ok_q && j_q == n_lim && have_q) st_d = StExpMul;
      StExpMul:  st_d = StExpSum;
      StExpSum:  st_d = StOut;
      StOut:     st_d = StIdle;
      default:   st_d = StIdle;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_take_o = 1'b0;
    if (st_q == StIdle && cmd_valid_i) begin
      cmd_take_o = (cmd_i.op != OpObs) || !rv_q;
    end
    raddr = j_q[AW-1:0];
  end

  assign dx   = absd(mx_q, rx_q);
  assign dy   = absd(my_q, ry_q);
  assign dsum = {33'd0, dx} * {33'd0, dx} + {33'd0, dy} * {33'd0, dy};

  // new running weight, saturated to 40 bits; a huge exponent pins it to the floor
  always_comb begin
    e_sum  = ex_q + ey_q;
    w_next = $signed({{2{ws_q[WeightW-1]}}, ws_q}) - 42'($signed(norm_i))
             - 42'($signed({1'b0, e_sum[40:0]}));
    if (e_sum > 61'(42'h0ffffffffff)) w_next = -42'sh10000000000;
    if (w_next > 42'sh07fffffffff) w_next = 42'sh07fffffffff;
    if (w_next < -42'sh08000000000) w_next = -42'sh08000000000;
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && cmd_take_o && cmd_i.op == OpLoad) begin
      tx_mem[cmd_i.slot[AW-1:0]]  <= cmd_i.xv;
      ty_mem[cmd_i.slot[AW-1:0]]  <= cmd_i.yv;
      tid_mem[cmd_i.slot[AW-1:0]] <= cmd_i.id;
    end
    rx_q  <= tx_mem[raddr];
    ry_q  <= ty_mem[raddr];
    rid_q <= tid_mem[raddr];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    logic [AngleBits-1:0] phase;
    logic [29:0]          r30;
    logic signed [61:0]   fx, fy;
    logic signed [31:0]   s, c, sv, cv;
    phase = (AngleBits >= 16) ? AngleBits'({ph_q, 8'd0} >> (24 - AngleBits))
                              : AngleBits'(ph_q >> (16 - AngleBits));
    r30   = 30'({phase[AngleBits-3:0], 30'd0} >> (AngleBits - 2));
    fx = '0; fy = '0; s = '0; c = '0; sv = '0; cv = '0;
    case (st_q)
      StIdle: begin
        if (cmd_take_o) cur_q <= cmd_i;
        xa_q   <= {1'b0, r30};
        xc_q   <= 31'h40000000 - {1'b0, r30};
        quad_q <= phase[AngleBits-1 -: 2];
        k_q    <= 3'd0;
      end
      StPoly: begin
        if (k_q == 3'd0) begin
          pa_q <= 63'(xa_q) * 63'(xa_q);
          pc_q <= 63'(xc_q) * 63'(xc_q);
        end else if (k_q == 3'd5) begin
          pa_q <= 63'(sa_q) * 63'(xa_q);
          pc_q <= 63'(sc_q) * 63'(xc_q);
        end else begin
          pa_q <= 63'(sa_q) * 63'(x2a_q);
          pc_q <= 63'(sc_q) * 63'(x2c_q);
        end
      end
      StPolyMul: begin
        if (k_q == 3'd0) begin
          x2a_q <= pa_q[60:30];
          x2c_q <= pc_q[60:30];
          sa_q  <= {1'b0, SinCoef[0]};
          sc_q  <= {1'b0, SinCoef[0]};
        end else if (k_q == 3'd5) begin
          sa_q <= (pa_q[62:30] > 33'h40000000) ? 32'h40000000 : pa_q[61:30];
          sc_q <= (pc_q[62:30] > 33'h40000000) ? 32'h40000000 : pc_q[61:30];
        end else begin
          sa_q <= {1'b0, SinCoef[k_q]} - pa_q[61:30];
          sc_q <= {1'b0, SinCoef[k_q]} - pc_q[61:30];
        end
        k_q <= k_q + 3'd1;
      end
      StRotMul: begin
        s = $signed(sa_q); c = $signed(sc_q);
        case (quad_q)
          2'd0: begin sv = s;  cv = c;  end
          2'd1: begin sv = c;  cv = -s; end
          2'd2: begin sv = -s; cv = -c; end
          default: begin sv = -c; cv = s; end
        endcase
        m1_q <= cv * $signed(cur_q.xv);
        m2_q <= sv * $signed(cur_q.yv);
        m3_q <= sv * $signed(cur_q.xv);
        m4_q <= cv * $signed(cur_q.yv);
      end
      StRotSum: begin
        fx = 62'((m1_q - m2_q) >>> 30);
        fy = 62'((m3_q + m4_q) >>> 30);
        mx_q <= sat32(34'($signed(px_q)) + 34'(fx));
        my_q <= sat32(34'($signed(py_q)) + 34'(fy));
        j_q     <= '0;
        rd_ok_q <= 1'b0;
        have_q  <= 1'b0;
      end
      StScan: begin
        // address j issued now, data compared next cycle
        rd_ok_q <= (j_q < n_lim);
        rd_j_q  <= j_q[AW-1:0];
        if (j_q < n_lim) j_q <= j_q + NW'(1);
        if (rd_ok_q && (!have_q || dsum[64:0] < bestd_q)) begin
          have_q  <= 1'b1;
          best_q  <= rd_j_q;
          bestd_q <= dsum[64:0];
          bdx_q   <= dx;
          bdy_q   <= dy;
          bid_q   <= rid_q;
          bx_q    <= rx_q;
          by_q    <= ry_q;
        end
      end
      StExpMul: begin
        sqx_q <= 66'(bdx_q) * 66'(bdx_q);
        sqy_q <= 66'(bdy_q) * 66'(bdy_q);
      end
      StExpSum: begin
        ex_q <= 61'(sqx_q[65:32] * 58'(ivx_i)) + 61'((sqx_q[31:0] * 56'(ivx_i)) >> 32);
        ey_q <= 61'(sqy_q[65:32] * 58'(ivy_i)) + 61'((sqy_q[31:0] * 56'(ivy_i)) >> 32);
      end
      StOut: begin
        res_q.idx <= SlotW'(best_q);
        res_q.id  <= bid_q;
        res_q.x   <= bx_q;
        res_q.y   <= by_q;
        res_q.w   <= w_next[WeightW-1:0];
        res_q.fin <= cur_q.last;
      end
      default: ;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      px_q <= '0;
      py_q <= '0;
      ph_q <= '0;
      ws_q <= '0;
      rv_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StIdle && cmd_take_o && cmd_i.op == OpPose) begin
        px_q <= cmd_i.xv;
        py_q <= cmd_i.yv;
        ph_q <= cmd_i.head;
        ws_q <= '0;
      end
      if (st_q == StOut) begin
        rv_q <= 1'b1;
        ws_q <= w_next[WeightW-1:0];
      end else if (res_take_i) begin
        rv_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = rv_q;
  assign res_o       = res_q;
endmodule
